FILE: rtl/core/hoq_pkg.sv
package hoq_pkg;

	// Event opcodes carried in each input beat
	typedef enum logic [2:0] {
		OP_EVALUATE  = 3'd0,
		OP_PAUSE     = 3'd1,
		OP_REARM     = 3'd2,
		OP_RESTART   = 3'd3,
		OP_RESET_QUAL = 3'd4
	} opcode_t;

	// Device kinds, with the unsupported reset code; codes above KIND_HUMIDIFIER are unsupported
	localparam logic [2:0] KIND_PURIFIER  = 3'd0;
	localparam logic [2:0] KIND_FAN       = 3'd1;
	localparam logic [2:0] KIND_HUMIDIFIER = 3'd2;
	localparam logic [2:0] KIND_RESET     = 3'd7;

	// Configuration register indexes
	localparam logic [1:0] CFG_AUTO_MODE   = 2'd0;
	localparam logic [1:0] CFG_DEVICE_KIND = 2'd1;
	localparam logic [1:0] CFG_ON_THRESH   = 2'd2;
	localparam logic [1:0] CFG_OFF_THRESH  = 2'd3;

	localparam int CFG_DATA_W = 16;

	// Sensor plausibility limits
	localparam logic [15:0] CO2_LIMIT = 16'd10000;
	localparam logic [9:0]  VOC_LIMIT = 10'd500;
	localparam logic [6:0]  HUM_LIMIT = 7'd100;

	// Timing and debounce
	localparam logic [31:0] HOLD_TIME_MS   = 32'd10000;
	localparam logic [3:0]  QUALIFY_FRAMES = 4'd3;

	// Flag bit positions
	localparam int VF_CO2 = 0;
	localparam int VF_VOC = 1;
	localparam int VF_HUM = 2;
	localparam int FF_BUS = 0;
	localparam int FF_CO2_TO = 1;
	localparam int FF_TH_TO = 2;

	typedef struct packed {
		logic        auto_mode;
		logic [2:0]  device_kind;
		logic [15:0] on_threshold;
		logic [15:0] off_threshold;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [31:0] now_ms;
		logic        link_up;
		logic        reported_on;
		logic [2:0]  valid_flags;
		logic [2:0]  fault_flags;
		logic [15:0] co2_reading;
		logic [9:0]  voc_reading;
		logic [6:0]  humidity_reading;
	} item_t;

	typedef struct packed {
		logic command_valid;
		logic desired_on;
		logic paused_flag;
		logic suspended_flag;
	} result_t;

endpackage

FILE: rtl/core/hoq_cfg.sv
module hoq_cfg
	import hoq_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	// Register file, one write per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.auto_mode     <= 1'b0;
			cfg_q.device_kind   <= KIND_RESET;
			cfg_q.on_threshold  <= '0;
			cfg_q.off_threshold <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_AUTO_MODE:   cfg_q.auto_mode     <= cfg_wdata[0];
				CFG_DEVICE_KIND: cfg_q.device_kind   <= cfg_wdata[2:0];
				CFG_ON_THRESH:   cfg_q.on_threshold  <= cfg_wdata[15:0];
				CFG_OFF_THRESH:  cfg_q.off_threshold <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/core/hoq_core.sv
module hoq_core
	import hoq_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    fire,
	input  item_t   item,
	output result_t result
);

	logic        paused_q, suspended_q, qualifying_q, qtarget_q;
	logic [3:0]  agree_q;
	logic [31:0] last_sw_q;

	logic        paused_d, suspended_d, qualifying_d, qtarget_d;
	logic [3:0]  agree_d;
	logic [31:0] last_sw_d;
	logic        issue, want;

	logic        kind_ok, bad, target, deadband;
	logic [15:0] val;
	logic [31:0] elapsed, now_nz;
	logic        hold_active;
	logic [3:0]  agree_new;

	// Reading selection and plausibility per device kind
	always_comb begin
		case (cfg.device_kind)
			KIND_FAN: begin
				bad = !item.valid_flags[VF_CO2] || item.fault_flags[FF_BUS]
					|| item.fault_flags[FF_CO2_TO] || (item.co2_reading > CO2_LIMIT);
				val = item.co2_reading;
			end
			KIND_PURIFIER: begin
				bad = !item.valid_flags[VF_VOC] || item.fault_flags[FF_BUS]
					|| item.fault_flags[FF_CO2_TO] || (item.voc_reading > VOC_LIMIT);
				val = {6'd0, item.voc_reading};
			end
			default: begin
				bad = !item.valid_flags[VF_HUM] || item.fault_flags[FF_BUS]
					|| item.fault_flags[FF_TH_TO] || (item.humidity_reading > HUM_LIMIT);
				val = {9'd0, item.humidity_reading};
			end
		endcase
	end

	// Hysteresis compare: humidifier turns on low, the others turn on high
	always_comb begin
		deadband = 1'b0;
		target   = 1'b0;
		if (cfg.device_kind == KIND_HUMIDIFIER) begin
			if (val <= cfg.on_threshold)       target = 1'b1;
			else if (val >= cfg.off_threshold) target = 1'b0;
			else                               deadband = 1'b1;
		end else begin
			if (val >= cfg.on_threshold)       target = 1'b1;
			else if (val <= cfg.off_threshold) target = 1'b0;
			else                               deadband = 1'b1;
		end
	end

	// Wrapping hold window
	assign elapsed     = item.now_ms - last_sw_q;
	assign hold_active = (last_sw_q != '0) && (elapsed < HOLD_TIME_MS);
	assign now_nz      = (item.now_ms != '0) ? item.now_ms : 32'd1;
	assign kind_ok     = cfg.auto_mode && (cfg.device_kind <= KIND_HUMIDIFIER);

	// Debounce counter step
	always_comb begin
		if (!qualifying_q || (qtarget_q != target))
			agree_new = 4'd1;
		else if (agree_q < QUALIFY_FRAMES)
			agree_new = agree_q + 4'd1;
		else
			agree_new = agree_q;
	end

	// Next state and result for the current beat
	always_comb begin
		paused_d     = paused_q;
		suspended_d  = suspended_q;
		qualifying_d = qualifying_q;
		qtarget_d    = qtarget_q;
		agree_d      = agree_q;
		last_sw_d    = last_sw_q;
		issue        = 1'b0;
		want         = 1'b0;
		case (item.opcode)
			OP_EVALUATE: begin
				if (!kind_ok || (!paused_q && !item.link_up)) begin
					qualifying_d = 1'b0;
					agree_d      = '0;
				end else if (!paused_q) begin
					qualifying_d = 1'b0;
					agree_d      = '0;
					if (bad) begin
						suspended_d = 1'b1;
					end else if (suspended_q) begin
						// recovery restarts the hold
						suspended_d = 1'b0;
						last_sw_d   = now_nz;
					end else if (!deadband && (target != item.reported_on) && !hold_active) begin
						if (agree_new >= QUALIFY_FRAMES) begin
							issue = 1'b1;
							want  = target;
						end else begin
							qualifying_d = 1'b1;
							qtarget_d    = target;
							agree_d      = agree_new;
						end
					end
				end
			end
			OP_PAUSE: begin
				paused_d     = 1'b1;
				qualifying_d = 1'b0;
				agree_d      = '0;
			end
			OP_REARM: begin
				paused_d     = 1'b0;
				qualifying_d = 1'b0;
				agree_d      = '0;
				last_sw_d    = item.now_ms;
			end
			OP_RESTART: begin
				last_sw_d    = now_nz;
				qualifying_d = 1'b0;
				agree_d      = '0;
			end
			OP_RESET_QUAL: begin
				qualifying_d = 1'b0;
				agree_d      = '0;
			end
			default: ;
		endcase
	end

	// Controller state, updated once per beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			paused_q     <= 1'b0;
			suspended_q  <= 1'b0;
			qualifying_q <= 1'b0;
			qtarget_q    <= 1'b0;
			agree_q      <= '0;
			last_sw_q    <= '0;
		end else if (fire) begin
			paused_q     <= paused_d;
			suspended_q  <= suspended_d;
			qualifying_q <= qualifying_d;
			qtarget_q    <= qtarget_d;
			agree_q      <= agree_d;
			last_sw_q    <= last_sw_d;
		end
	end

	assign result.command_valid  = issue;
	assign result.desired_on     = issue & want;
	assign result.paused_flag    = paused_d;
	assign result.suspended_flag = suspended_d;

endmodule

FILE: rtl/core/hysteresis_onoff_qualifier.sv
// Hysteresis on/off qualifier: takes one sensor status beat or event opcode
// per cycle while in_ready is high and returns exactly one result beat for
// each. An accepted beat waits in the input register until the result register
// is free or being read (input register, then decision logic into the result
// register); throughput is one beat per cycle unless the output stalls, set
// by the single state update done as a beat leaves the input register.
// in_ready drops only while the result register is full and out_ready is low.
// Configuration writes through cfg_we/cfg_addr/cfg_wdata take effect at once
// and must be made only while no beat is in flight.
module hysteresis_onoff_qualifier
	import hoq_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [2:0]            opcode,
	input  logic [31:0]           now_ms,
	input  logic                  link_up,
	input  logic                  reported_on,
	input  logic [2:0]            valid_flags,
	input  logic [2:0]            fault_flags,
	input  logic [15:0]           co2_reading,
	input  logic [9:0]            voc_reading,
	input  logic [6:0]            humidity_reading,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  command_valid,
	output logic                  desired_on,
	output logic                  paused_flag,
	output logic                  suspended_flag
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	logic    advance;
	result_t res_d;
	result_t res_q;
	logic    out_valid_q;

	hoq_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Pipeline control
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.opcode           <= opcode;
			item_s1.now_ms           <= now_ms;
			item_s1.link_up          <= link_up;
			item_s1.reported_on      <= reported_on;
			item_s1.valid_flags      <= valid_flags;
			item_s1.fault_flags      <= fault_flags;
			item_s1.co2_reading      <= co2_reading;
			item_s1.voc_reading      <= voc_reading;
			item_s1.humidity_reading <= humidity_reading;
		end
	end

	hoq_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.fire   (advance),
		.item   (item_s1),
		.result (res_d)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign command_valid  = res_q.command_valid;
	assign desired_on     = res_q.desired_on;
	assign paused_flag    = res_q.paused_flag;
	assign suspended_flag = res_q.suspended_flag;

endmodule

FILE: rtl/core/hoq_checker.sv
module hoq_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic command_valid,
	input logic desired_on,
	input logic paused_flag,
	input logic suspended_flag
);

	// A stalled result beat holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(command_valid)
			&& $stable(desired_on) && $stable(paused_flag) && $stable(suspended_flag))
		else $error("result beat changed while stalled");

	// An empty result register never back-pressures the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result register");

	// A newly risen result beat must trace back to an accepted input beat
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result beat without an input beat");

	// Commands come only from an active, healthy controller
	a_cmd_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && command_valid |-> !paused_flag && !suspended_flag)
		else $error("command issued while paused or suspended");

	// desired_on only rides on a command
	a_desired_gated: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && desired_on |-> command_valid)
		else $error("desired_on without command");

endmodule

bind hysteresis_onoff_qualifier hoq_checker u_hoq_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.command_valid  (command_valid),
	.desired_on     (desired_on),
	.paused_flag    (paused_flag),
	.suspended_flag (suspended_flag)
);

FILE: test/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import hoq_pkg::*;

	localparam int CYCLE_LIMIT      = 300000;
	localparam int RAND_PHASES      = 11;
	localparam int FRAMES_PER_PHASE = 75;
	localparam int QUIET_PHASES     = 2;
	localparam int DRAIN_CYCLES     = 4;
	localparam int MAX_PRINTS       = 40;

	// Opcodes the block must ignore
	localparam logic [2:0] OP_SPARE_LO = 3'd5;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;

	// Status beats that can be read off directly
	localparam result_t RES_QUIET     = 4'b0000;
	localparam result_t RES_PAUSED    = 4'b0010;
	localparam result_t RES_SUSPENDED = 4'b0001;

	// Source of a directed row's expectation
	localparam bit PINNED    = 1'b1;
	localparam bit PREDICTED = 1'b0;

	typedef enum int {ZONE_ON, ZONE_OFF, ZONE_DEAD} zone_t;

	typedef struct {
		bit          is_cfg;
		logic [1:0]  reg_idx;
		logic [15:0] reg_val;
		item_t       frame;
		bit          pinned;
		result_t     want;
	} plan_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [1:0]            cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  in_valid;
	logic                  in_ready;
	item_t                 frame;
	logic                  out_valid;
	logic                  out_ready;
	logic                  command_valid;
	logic                  desired_on;
	logic                  paused_flag;
	logic                  suspended_flag;

	// Shadow configuration and controller state
	logic        cfg_auto;
	logic [2:0]  cfg_kind;
	logic [15:0] cfg_on;
	logic [15:0] cfg_off;
	logic        ctl_paused;
	logic        ctl_suspended;
	logic        ctl_qualifying;
	logic        ctl_qual_target;
	logic [3:0]  ctl_agree;
	logic [31:0] ctl_last_switch;

	result_t   pending_status_q[$];
	plan_row_t plan_q[$];

	// Stimulus bookkeeping
	bit          tx_idle_en;
	bit          rx_idle_en;
	bit          row_pinned;
	result_t     row_want;
	logic [31:0] clock_ms;
	logic        dev_on;
	zone_t       zone;

	int mismatch_cnt;
	int n_frames;
	int n_results;
	int n_cmd_on;
	int n_cmd_off;
	int n_susp;
	int n_settings;

	hysteresis_onoff_qualifier dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_addr         (cfg_addr),
		.cfg_wdata        (cfg_wdata),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.opcode           (frame.opcode),
		.now_ms           (frame.now_ms),
		.link_up          (frame.link_up),
		.reported_on      (frame.reported_on),
		.valid_flags      (frame.valid_flags),
		.fault_flags      (frame.fault_flags),
		.co2_reading      (frame.co2_reading),
		.voc_reading      (frame.voc_reading),
		.humidity_reading (frame.humidity_reading),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.command_valid    (command_valid),
		.desired_on       (desired_on),
		.paused_flag      (paused_flag),
		.suspended_flag   (suspended_flag)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		mismatch_cnt++;
		if (mismatch_cnt <= MAX_PRINTS)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	function automatic void drop_qualify();
		ctl_agree = '0;
		ctl_qualifying = 1'b0;
	endfunction

	// Next status beat of the controller for one input beat
	function automatic result_t predict_status(input item_t f);
		result_t     r;
		logic        go;
		logic        bad;
		logic        want;
		logic [15:0] level;
		r = RES_QUIET;
		go = 1'b0;
		bad = 1'b0;
		want = 1'b0;
		level = '0;
		case (f.opcode)
			OP_EVALUATE: begin
				go = 1'b1;
				if (!cfg_auto || cfg_kind > KIND_HUMIDIFIER) begin
					drop_qualify();
					go = 1'b0;
				end else if (ctl_paused) begin
					go = 1'b0;
				end else if (!f.link_up) begin
					drop_qualify();
					go = 1'b0;
				end
				// Sensor selection and plausibility
				if (go) begin
					case (cfg_kind)
						KIND_FAN: begin
							level = f.co2_reading;
							bad = !f.valid_flags[VF_CO2] || f.fault_flags[FF_BUS] ||
								f.fault_flags[FF_CO2_TO] || f.co2_reading > CO2_LIMIT;
						end
						KIND_PURIFIER: begin
							level = 16'(f.voc_reading);
							bad = !f.valid_flags[VF_VOC] || f.fault_flags[FF_BUS] ||
								f.fault_flags[FF_CO2_TO] || f.voc_reading > VOC_LIMIT;
						end
						default: begin
							level = 16'(f.humidity_reading);
							bad = !f.valid_flags[VF_HUM] || f.fault_flags[FF_BUS] ||
								f.fault_flags[FF_TH_TO] || f.humidity_reading > HUM_LIMIT;
						end
					endcase
					if (bad) begin
						ctl_suspended = 1'b1;
						drop_qualify();
						go = 1'b0;
					end else if (ctl_suspended) begin
						// recovery restarts the hold, zero time maps to one
						ctl_suspended = 1'b0;
						ctl_last_switch = (f.now_ms != '0) ? f.now_ms : 32'd1;
						drop_qualify();
						go = 1'b0;
					end
				end
				// Hysteresis compare, reported state and hold window
				if (go) begin
					if (cfg_kind == KIND_HUMIDIFIER) begin
						if (level <= cfg_on) want = 1'b1;
						else if (level >= cfg_off) want = 1'b0;
						else go = 1'b0;
					end else begin
						if (level >= cfg_on) want = 1'b1;
						else if (level <= cfg_off) want = 1'b0;
						else go = 1'b0;
					end
					if (!go || want == f.reported_on) begin
						drop_qualify();
						go = 1'b0;
					end else if (ctl_last_switch != '0 &&
							(f.now_ms - ctl_last_switch) < HOLD_TIME_MS) begin
						drop_qualify();
						go = 1'b0;
					end
				end
				// Debounce over consecutive agreeing frames
				if (go) begin
					if (!ctl_qualifying || ctl_qual_target != want) begin
						ctl_qualifying = 1'b1;
						ctl_qual_target = want;
						ctl_agree = 4'd1;
					end else if (ctl_agree < QUALIFY_FRAMES) begin
						ctl_agree = ctl_agree + 4'd1;
					end
					if (ctl_agree >= QUALIFY_FRAMES) begin
						drop_qualify();
						r.command_valid = 1'b1;
						r.desired_on = want;
					end
				end
			end
			OP_PAUSE: begin
				ctl_paused = 1'b1;
				drop_qualify();
			end
			OP_REARM: begin
				ctl_paused = 1'b0;
				drop_qualify();
				ctl_last_switch = f.now_ms;
			end
			OP_RESTART: begin
				ctl_last_switch = (f.now_ms != '0) ? f.now_ms : 32'd1;
				drop_qualify();
			end
			OP_RESET_QUAL: drop_qualify();
			default: ;
		endcase
		r.paused_flag = ctl_paused;
		r.suspended_flag = ctl_suspended;
		return r;
	endfunction

	// Accepted input beats feed the predictor, result beats are checked in order
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && in_valid && in_ready) begin
			want = predict_status(frame);
			if (want.command_valid)
				dev_on = want.desired_on;
			if (row_pinned)
				want = row_want;
			pending_status_q.push_back(want);
			n_frames++;
		end
		if (arst_n && out_valid && out_ready) begin
			got = {command_valid, desired_on, paused_flag, suspended_flag};
			if (pending_status_q.size() == 0) begin
				report_mismatch($sformatf("result beat %b with nothing pending", got));
			end else begin
				want = pending_status_q.pop_front();
				if (got.command_valid !== want.command_valid)
					report_mismatch($sformatf("beat %0d command_valid got %b want %b",
						n_results, got.command_valid, want.command_valid));
				if (got.desired_on !== want.desired_on)
					report_mismatch($sformatf("beat %0d desired_on got %b want %b",
						n_results, got.desired_on, want.desired_on));
				if (got.paused_flag !== want.paused_flag)
					report_mismatch($sformatf("beat %0d paused_flag got %b want %b",
						n_results, got.paused_flag, want.paused_flag));
				if (got.suspended_flag !== want.suspended_flag)
					report_mismatch($sformatf("beat %0d suspended_flag got %b want %b",
						n_results, got.suspended_flag, want.suspended_flag));
				n_results++;
				if (want.command_valid && want.desired_on) n_cmd_on++;
				if (want.command_valid && !want.desired_on) n_cmd_off++;
				if (want.suspended_flag) n_susp++;
			end
		end
	end

	// Result side backpressure in random bursts
	initial begin
		forever begin
			@(negedge clk);
			if (rx_idle_en && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("timeout after %0d cycles, %0d beats pending", CYCLE_LIMIT,
			pending_status_q.size());
		$display("TEST FAILED");
		$finish;
	end

	// Present one input beat, holding it until accepted
	task automatic send_frame(input item_t f, input bit pinned, input result_t want);
		int gap;
		@(negedge clk);
		if (tx_idle_en && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 12);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		row_pinned = pinned;
		row_want = want;
		frame <= f;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_status_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		case (idx)
			CFG_AUTO_MODE:   cfg_auto = val[0];
			CFG_DEVICE_KIND: cfg_kind = val[2:0];
			CFG_ON_THRESH:   cfg_on = val;
			CFG_OFF_THRESH:  cfg_off = val;
			default: ;
		endcase
	endtask

	task automatic close_cfg();
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic void add_cfg(input logic [1:0] idx, input logic [15:0] val);
		plan_row_t row;
		row.is_cfg = 1'b1;
		row.reg_idx = idx;
		row.reg_val = val;
		row.frame = '0;
		row.pinned = PREDICTED;
		row.want = RES_QUIET;
		plan_q.push_back(row);
	endfunction

	function automatic void add_frame(input logic [2:0] op, input logic [31:0] now,
			input logic link, input logic rep, input logic [2:0] vf, input logic [2:0] ff,
			input logic [15:0] co2, input logic [9:0] voc, input logic [6:0] hum,
			input bit pinned, input result_t want);
		plan_row_t row;
		row.is_cfg = 1'b0;
		row.reg_idx = CFG_AUTO_MODE;
		row.reg_val = '0;
		row.frame = '{op, now, link, rep, vf, ff, co2, voc, hum};
		row.pinned = pinned;
		row.want = want;
		plan_q.push_back(row);
	endfunction

	// Reading that lands in the current zone for the configured kind
	function automatic int pick_level();
		int lim;
		int lo;
		int hi;
		lim = (cfg_kind == KIND_FAN) ? int'(CO2_LIMIT) :
			(cfg_kind == KIND_PURIFIER) ? int'(VOC_LIMIT) : int'(HUM_LIMIT);
		if (cfg_kind == KIND_HUMIDIFIER) begin
			case (zone)
				ZONE_ON:  begin lo = 0; hi = (cfg_on < lim) ? cfg_on : lim; end
				ZONE_OFF: begin lo = (cfg_off < lim) ? cfg_off : lim; hi = lim; end
				default:  begin lo = cfg_on + 1; hi = cfg_off - 1; end
			endcase
		end else begin
			case (zone)
				ZONE_ON:  begin lo = (cfg_on < lim) ? cfg_on : lim; hi = lim; end
				ZONE_OFF: begin lo = 0; hi = (cfg_off < lim) ? cfg_off : lim; end
				default:  begin lo = cfg_off + 1; hi = cfg_on - 1; end
			endcase
		end
		if (hi < lo) hi = lo;
		return $urandom_range(lo, hi);
	endfunction

	// Mostly plausible evaluate frames with a moving clock, plus events and noise
	function automatic item_t make_frame();
		item_t f;
		int    pick;
		int    level;
		pick = $urandom_range(0, 99);
		if (pick < 85) f.opcode = OP_EVALUATE;
		else if (pick < 87) f.opcode = OP_PAUSE;
		else if (pick < 91) f.opcode = OP_REARM;
		else if (pick < 94) f.opcode = OP_RESTART;
		else if (pick < 97) f.opcode = OP_RESET_QUAL;
		else f.opcode = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
		if ($urandom_range(0, 99) < 3) clock_ms = $urandom;
		else clock_ms += $urandom_range(0, 4000);
		f.now_ms = clock_ms;
		f.link_up = ($urandom_range(0, 19) != 0);
		if ($urandom_range(0, 11) == 0) dev_on = !dev_on;
		f.reported_on = dev_on;
		f.valid_flags = ($urandom_range(0, 9) == 0) ? 3'($urandom) : 3'b111;
		f.fault_flags = ($urandom_range(0, 9) == 0) ? 3'($urandom) : 3'b000;
		f.co2_reading = 16'($urandom);
		f.voc_reading = 10'($urandom);
		f.humidity_reading = 7'($urandom);
		if ($urandom_range(0, 3) == 0) zone = zone_t'($urandom_range(0, 2));
		if ($urandom_range(0, 19) != 0) begin
			level = pick_level();
			case (cfg_kind)
				KIND_FAN:        f.co2_reading = 16'(level);
				KIND_PURIFIER:   f.voc_reading = 10'(level);
				KIND_HUMIDIFIER: f.humidity_reading = 7'(level);
				default: ;
			endcase
		end
		return f;
	endfunction

	initial begin
		logic [2:0]  kind;
		logic [15:0] on_lvl;
		logic [15:0] off_lvl;
		bit          auto_on;
		bit          quiet;
		bit          cfg_open;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = CFG_AUTO_MODE;
		cfg_wdata = '0;
		in_valid = 1'b0;
		frame = '0;
		out_ready = 1'b0;
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		row_pinned = 1'b0;
		row_want = RES_QUIET;
		clock_ms = '0;
		dev_on = 1'b0;
		zone = ZONE_ON;
		cfg_auto = 1'b0;
		cfg_kind = KIND_RESET;
		cfg_on = '0;
		cfg_off = '0;
		ctl_paused = 1'b0;
		ctl_suspended = 1'b0;
		ctl_qualifying = 1'b0;
		ctl_qual_target = 1'b0;
		ctl_agree = '0;
		ctl_last_switch = '0;
		cfg_open = 1'b0;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset state: manual mode, unsupported kind, then ignored code at top values
		add_frame(OP_EVALUATE, 32'd0, 1'b1, 1'b0, 3'b111, 3'b000, 16'd1200, 10'd100, 7'd40,
			PINNED, RES_QUIET);
		add_frame(OP_SPARE_HI, '1, 1'b1, 1'b1, 3'b111, 3'b111, '1, '1, '1, PINNED, RES_QUIET);
		add_frame(OP_PAUSE, 32'd10, 1'b0, 1'b0, 3'b000, 3'b000, 16'd0, 10'd0, 7'd0,
			PINNED, RES_PAUSED);
		add_frame(OP_EVALUATE, 32'd20, 1'b1, 1'b1, 3'b111, 3'b000, 16'd1200, 10'd0, 7'd0,
			PINNED, RES_PAUSED);
		add_frame(OP_REARM, 32'd0, 1'b1, 1'b0, 3'b000, 3'b000, 16'd0, 10'd0, 7'd0,
			PINNED, RES_QUIET);
		// Fan on CO2: implausible, bus fault, recovery, hold, debounce both ways
		add_cfg(CFG_AUTO_MODE, 16'd1);
		add_cfg(CFG_DEVICE_KIND, 16'(KIND_FAN));
		add_cfg(CFG_ON_THRESH, 16'd1000);
		add_cfg(CFG_OFF_THRESH, 16'd800);
		add_frame(OP_EVALUATE, 32'd0, 1'b1, 1'b0, 3'b111, 3'b000, 16'd10001, 10'd0, 7'd0,
			PINNED, RES_SUSPENDED);
		add_frame(OP_EVALUATE, 32'd0, 1'b1, 1'b0, 3'b111, 3'b001, 16'd10000, 10'd0, 7'd0,
			PINNED, RES_SUSPENDED);
		add_frame(OP_EVALUATE, 32'd0, 1'b1, 1'b0, 3'b111, 3'b000, 16'd1200, 10'd0, 7'd0,
			PINNED, RES_QUIET);
		add_frame(OP_EVALUATE, 32'd5000, 1'b1, 1'b0, 3'b111, 3'b000, 16'd1200, 10'd0, 7'd0,
			PREDICTED, RES_QUIET);
		add_frame(OP_EVALUATE, 32'd10001, 1'b1, 1'b0, 3'b111, 3'b000, 16'd1200, 10'd0, 7'd0,
			PREDICTED, RES_QUIET);
		add_frame(OP_EVALUATE, 32'd10002, 1'b1, 1'b0, 3'b111, 3'b000, 16'd1000, 10'd0, 7'd0,
			PREDICTED, RES_QUIET);
		add_frame(OP_EVALUATE, 32'd10003, 1'b1, 1'b0, 3'b111, 3'b000, 16'd1200, 10'd0, 7'd0,
			PREDICTED, RES_QUIET);
		add_frame(OP_EVALUATE, 32'd10004, 1'b0, 1'b0, 3'b111, 3'b000, 16'd1200, 10'd0, 7'd0,
			PREDICTED, RES_QUIET);
		add_frame(OP_EVALUATE, 32'd10005, 1'b1, 1'b0, 3'b111, 3'b000, 16'd900, 10'd0, 7'd0,
			PREDICTED, RES_QUIET);
		add_frame(OP_EVALUATE, 32'd20000, 1'b1, 1'b1, 3'b001, 3'b000, 16'd800, 10'd0, 7'd0,
			PREDICTED, RES_QUIET);
		add_frame(OP_EVALUATE, 32'd20001, 1'b1, 1'b1, 3'b111, 3'b000, 16'd0, 10'd0, 7'd0,
			PREDICTED, RES_QUIET);
		add_frame(OP_EVALUATE, 32'd20002, 1'b1, 1'b1, 3'b111, 3'b000, 16'd800, 10'd0, 7'd0,
			PREDICTED, RES_QUIET);
		// Humidifier with extreme thresholds: timeouts, limit, wrapped hold
		add_cfg(CFG_DEVICE_KIND, 16'(KIND_HUMIDIFIER));
		add_cfg(CFG_ON_THRESH, 16'd0);
		add_cfg(CFG_OFF_THRESH, 16'hFFFF);
		add_frame(OP_EVALUATE, 32'hFFFF_FFF0, 1'b1, 1'b0, 3'b100, 3'b010, 16'd0, 10'd0, 7'd0,
			PREDICTED, RES_QUIET);
		add_frame(OP_EVALUATE, 32'hFFFF_FFF1, 1'b1, 1'b0, 3'b100, 3'b100, 16'd0, 10'd0, 7'd0,
			PINNED, RES_SUSPENDED);
		add_frame(OP_EVALUATE, 32'hFFFF_FFF2, 1'b1, 1'b0, 3'b100, 3'b000, 16'd0, 10'd0, 7'd101,
			PINNED, RES_SUSPENDED);
		add_frame(OP_EVALUATE, 32'd0, 1'b1, 1'b0, 3'b100, 3'b000, 16'd0, 10'd0, 7'd100,
			PINNED, RES_QUIET);
		add_frame(OP_RESTART, 32'hFFFF_FFFF, 1'b1, 1'b0, 3'b000, 3'b000, 16'd0, 10'd0, 7'd0,
			PREDICTED, RES_QUIET);
		add_frame(OP_EVALUATE, 32'd5, 1'b1, 1'b0, 3'b100, 3'b000, 16'd0, 10'd0, 7'd100,
			PREDICTED, RES_QUIET);
		// Purifier on VOC with inverted extremes
		add_cfg(CFG_DEVICE_KIND, 16'(KIND_PURIFIER));
		add_cfg(CFG_ON_THRESH, 16'hFFFF);
		add_cfg(CFG_OFF_THRESH, 16'd0);
		add_frame(OP_EVALUATE, 32'd100, 1'b1, 1'b0, 3'b010, 3'b000, 16'd0, 10'd501, 7'd0,
			PINNED, RES_SUSPENDED);
		add_frame(OP_EVALUATE, 32'd200, 1'b1, 1'b0, 3'b010, 3'b010, 16'd0, 10'd500, 7'd0,
			PINNED, RES_SUSPENDED);
		add_frame(OP_EVALUATE, 32'd0, 1'b1, 1'b0, 3'b010, 3'b000, 16'd0, 10'd0, 7'd0,
			PINNED, RES_QUIET);
		add_frame(OP_RESET_QUAL, 32'd300, 1'b1, 1'b0, 3'b000, 3'b000, 16'd0, 10'd0, 7'd0,
			PREDICTED, RES_QUIET);
		add_frame(OP_EVALUATE, 32'd20000, 1'b1, 1'b1, 3'b010, 3'b000, 16'd0, 10'd0, 7'd0,
			PREDICTED, RES_QUIET);

		foreach (plan_q[i]) begin
			if (plan_q[i].is_cfg) begin
				if (!cfg_open) drain();
				write_reg(plan_q[i].reg_idx, plan_q[i].reg_val);
				cfg_open = 1'b1;
			end else begin
				if (cfg_open) begin
					close_cfg();
					n_settings++;
				end
				cfg_open = 1'b0;
				send_frame(plan_q[i].frame, plan_q[i].pinned, plan_q[i].want);
			end
		end

		// Random phases, each under a fresh register setting
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			drain();
			auto_on = ($urandom_range(0, 9) != 0);
			if ($urandom_range(0, 4) != 0)
				kind = 3'($urandom_range(KIND_PURIFIER, KIND_HUMIDIFIER));
			else
				kind = 3'($urandom_range(KIND_HUMIDIFIER + 1, KIND_RESET));
			case (kind)
				KIND_FAN: begin
					on_lvl = 16'($urandom_range(600, 3000));
					off_lvl = on_lvl - 16'($urandom_range(0, 400));
				end
				KIND_PURIFIER: begin
					on_lvl = 16'($urandom_range(100, 450));
					off_lvl = on_lvl - 16'($urandom_range(0, 80));
				end
				default: begin
					on_lvl = 16'($urandom_range(20, 50));
					off_lvl = on_lvl + 16'($urandom_range(0, 30));
				end
			endcase
			if ($urandom_range(0, 9) == 0) begin
				on_lvl = 16'($urandom);
				off_lvl = 16'($urandom);
			end
			write_reg(CFG_AUTO_MODE, 16'(auto_on));
			write_reg(CFG_DEVICE_KIND, 16'(kind));
			write_reg(CFG_ON_THRESH, on_lvl);
			write_reg(CFG_OFF_THRESH, off_lvl);
			close_cfg();
			n_settings++;

			quiet = (ph >= RAND_PHASES - QUIET_PHASES);
			tx_idle_en = !quiet && ($urandom_range(0, 3) != 0);
			rx_idle_en = !quiet && ($urandom_range(0, 3) != 0);
			clock_ms = (ph == 2) ? 32'hFFFF_C000 : $urandom;
			for (int k = 0; k < FRAMES_PER_PHASE; k++)
				send_frame(make_frame(), PREDICTED, RES_QUIET);
		end

		drain();
		repeat (DRAIN_CYCLES * 4) @(posedge clk);
		if (pending_status_q.size() != 0)
			report_mismatch($sformatf("%0d status beats never arrived",
				pending_status_q.size()));

		$display("Checked %0d status beats from %0d frames under %0d register settings.",
			n_results, n_frames, n_settings);
		$display("Switch commands: %0d on, %0d off; %0d beats while suspended.",
			n_cmd_on, n_cmd_off, n_susp);
		if (mismatch_cnt == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
